@@ design/chi_pkg.sv @@
`timescale 1ns / 1ps

package chi_pkg;

  // Grid and number formats
  localparam int MAX_POINTS  = 64;
  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_BITS    = 6;
  localparam int CNT_BITS    = 7;
  localparam int OP_BITS     = 2;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int RES_BITS    = 18;
  localparam int MIN_POINTS  = 3;

  localparam logic [FRAC_W-1:0]   ONE_FRAC          = FRAC_W'(1) << FRAC_BITS;
  localparam logic [CNT_BITS-1:0] POINT_COUNT_RESET = CNT_BITS'(MIN_POINTS);

  // Queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  // Datapath widths: twice-slope, cubic and quadratic coefficients, Horner partials
  localparam int DS_W     = SAMPLE_BITS + 3;
  localparam int DD_W     = SAMPLE_BITS + 5;
  localparam int C_W      = SAMPLE_BITS + 6;
  localparam int X1_W     = DD_W + FRAC_W + 1;
  localparam int X1_LO_W  = X1_W / 2 + 1;
  localparam int X1_HI_W  = X1_W - X1_LO_W;
  localparam int P1H_W    = X1_HI_W + FRAC_W + 1;
  localparam int P1L_W    = X1_LO_W + FRAC_W;
  localparam int X2_W     = X1_W + FRAC_W + 1;
  localparam int X2_LO_W  = X2_W / 2;
  localparam int X2_HI_W  = X2_W - X2_LO_W;
  localparam int P2H_W    = X2_HI_W + FRAC_W + 1;
  localparam int P2L_W    = X2_LO_W + FRAC_W;
  localparam int X3_W     = RES_BITS + 3 * FRAC_BITS + 1;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_LOAD_SAMPLE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_SLOPE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_EVALUATE    = 2'd2;

  // Configuration register indexes
  localparam logic REG_POINT_COUNT  = 1'b0;
  localparam logic REG_SLOPE_SOURCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD_Y = 2'd0,
    KIND_LOAD_S = 2'd1,
    KIND_EVAL   = 2'd2,
    KIND_ERR    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [OP_BITS-1:0]            operation;
    logic [IDX_BITS-1:0]           point_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [FRAC_W-1:0]             fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] result;
    logic                       status;
  } out_item_t;

  typedef struct packed {
    kind_t                         kind;
    logic [IDX_BITS-1:0]           index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [FRAC_W-1:0]             frac;
    logic                          first;
    logic                          last;
  } mid_item_t;

  typedef struct packed {
    logic slope_source;
  } cfg_t;

endpackage

@@ design/chi_queue.sv @@
`timescale 1ns / 1ps

module chi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = chi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

@@ design/chi_front.sv @@
`timescale 1ns / 1ps

module chi_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push_i,
  input  chi_pkg::in_item_t              in_data_i,
  output logic                           in_full_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_index_i,
  input  logic [chi_pkg::CNT_BITS-1:0]   cfg_data_i,
  output logic                           cfg_ready_o,
  output chi_pkg::cfg_t                  cfg_o,
  output logic                           mid_push_o,
  output chi_pkg::mid_item_t             mid_data_o,
  input  logic                           mid_full_i
);

  logic [chi_pkg::CNT_BITS-1:0] point_count_r;
  logic                         slope_source_r;
  logic [chi_pkg::CNT_BITS-1:0] n_eff;
  logic [chi_pkg::CNT_BITS-1:0] idx_ext;
  logic                         seg_err;
  logic                         keep;
  chi_pkg::kind_t               kind;

  assign cfg_ready_o        = 1'b1;
  assign cfg_o.slope_source = slope_source_r;
  assign in_full_o          = mid_full_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r  <= chi_pkg::POINT_COUNT_RESET;
      slope_source_r <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        chi_pkg::REG_POINT_COUNT:  point_count_r  <= cfg_data_i;
        chi_pkg::REG_SLOPE_SOURCE: slope_source_r <= cfg_data_i[0];
      endcase
    end
  end

  // Clamp the point count to the usable grid
  always_comb begin
    priority if (point_count_r < chi_pkg::CNT_BITS'(chi_pkg::MIN_POINTS)) begin
      n_eff = chi_pkg::CNT_BITS'(chi_pkg::MIN_POINTS);
    end else if (point_count_r > chi_pkg::CNT_BITS'(chi_pkg::MAX_POINTS)) begin
      n_eff = chi_pkg::CNT_BITS'(chi_pkg::MAX_POINTS);
    end else begin
      n_eff = point_count_r;
    end
  end

  assign idx_ext = chi_pkg::CNT_BITS'(in_data_i.point_index);
  assign seg_err = (idx_ext + chi_pkg::CNT_BITS'(1)) >= n_eff;

  always_comb begin
    keep = 1'b1;
    kind = chi_pkg::KIND_EVAL;
    unique case (in_data_i.operation)
      chi_pkg::OP_LOAD_SAMPLE: begin
        kind = chi_pkg::KIND_LOAD_Y;
        keep = idx_ext < chi_pkg::CNT_BITS'(chi_pkg::MAX_POINTS);
      end
      chi_pkg::OP_LOAD_SLOPE: begin
        kind = chi_pkg::KIND_LOAD_S;
        keep = idx_ext < chi_pkg::CNT_BITS'(chi_pkg::MAX_POINTS);
      end
      chi_pkg::OP_EVALUATE: begin
        kind = seg_err ? chi_pkg::KIND_ERR : chi_pkg::KIND_EVAL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    mid_data_o.kind  = kind;
    mid_data_o.index = in_data_i.point_index;
    mid_data_o.value = in_data_i.value;
    mid_data_o.frac  = (in_data_i.fraction > chi_pkg::ONE_FRAC) ? chi_pkg::ONE_FRAC
                                                                : in_data_i.fraction;
    mid_data_o.first = (in_data_i.point_index == '0);
    // segment ends at the last grid point
    mid_data_o.last  = ((idx_ext + chi_pkg::CNT_BITS'(2)) == n_eff);
  end

  // Drop unused operations at the door
  assign mid_push_o = in_push_i && keep && !mid_full_i;

endmodule

@@ design/chi_back.sv @@
`timescale 1ns / 1ps

module chi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  chi_pkg::cfg_t       cfg_i,
  input  chi_pkg::mid_item_t  mid_data_i,
  input  logic                mid_empty_i,
  output logic                mid_pop_o,
  output logic                out_push_o,
  output chi_pkg::out_item_t  out_data_o,
  input  logic                out_full_i
);

  localparam int SB = chi_pkg::SAMPLE_BITS;
  localparam int FW = chi_pkg::FRAC_W;
  localparam int AW = chi_pkg::IDX_BITS;

  logic signed [SB-1:0] ya_mem [chi_pkg::MAX_POINTS];
  logic signed [SB-1:0] yb_mem [chi_pkg::MAX_POINTS];
  logic signed [SB-1:0] sl_mem [chi_pkg::MAX_POINTS];

  chi_pkg::mid_item_t item;
  logic               adv;
  logic               wr_y, wr_s, is_calc;
  logic [AW-1:0]      addr_m1, addr_p1, addr_p2;

  // stage 1: table reads
  logic                 s1_valid_r, s1_err_r, s1_first_r, s1_last_r;
  logic [FW-1:0]        s1_frac_r;
  logic signed [SB-1:0] ym1_r, y0_r, y1_r, y2_r, sl0_r, sl1_r;
  // stage 2: twice slopes
  logic                        s2_valid_r, s2_err_r;
  logic [FW-1:0]               s2_frac_r;
  logic signed [SB-1:0]        s2_y0_r, s2_y1_r;
  logic signed [chi_pkg::DS_W-1:0] s2_d0_r, s2_d1_r;
  // stage 3: polynomial coefficients
  logic                        s3_valid_r, s3_err_r;
  logic [FW-1:0]               s3_frac_r;
  logic signed [SB-1:0]        s3_y0_r;
  logic signed [chi_pkg::DS_W-1:0] s3_d0_r;
  logic signed [chi_pkg::DD_W-1:0] s3_dd_r;
  logic signed [chi_pkg::C_W-1:0]  s3_c_r;
  // stage 4: cubic term times t
  logic                        s4_valid_r, s4_err_r;
  logic [FW-1:0]               s4_frac_r;
  logic signed [SB-1:0]        s4_y0_r;
  logic signed [chi_pkg::DS_W-1:0] s4_d0_r;
  logic signed [chi_pkg::C_W-1:0]  s4_c_r;
  logic signed [chi_pkg::X1_W-1:0] s4_m1_r;
  // stage 5: first Horner sum
  logic                        s5_valid_r, s5_err_r;
  logic [FW-1:0]               s5_frac_r;
  logic signed [SB-1:0]        s5_y0_r;
  logic signed [chi_pkg::DS_W-1:0] s5_d0_r;
  logic signed [chi_pkg::X1_W-1:0] s5_x1_r;
  // stage 6: split product
  logic                        s6_valid_r, s6_err_r;
  logic [FW-1:0]               s6_frac_r;
  logic signed [SB-1:0]        s6_y0_r;
  logic signed [chi_pkg::DS_W-1:0]  s6_d0_r;
  logic signed [chi_pkg::P1H_W-1:0] s6_ph_r;
  logic [chi_pkg::P1L_W-1:0]        s6_pl_r;
  // stage 7: second Horner sum
  logic                        s7_valid_r, s7_err_r;
  logic [FW-1:0]               s7_frac_r;
  logic signed [SB-1:0]        s7_y0_r;
  logic signed [chi_pkg::X2_W-1:0] s7_x2_r;
  // stage 8: split product
  logic                        s8_valid_r, s8_err_r;
  logic signed [SB-1:0]        s8_y0_r;
  logic signed [chi_pkg::P2H_W-1:0] s8_ph_r;
  logic [chi_pkg::P2L_W-1:0]        s8_pl_r;

  assign item      = mid_data_i;
  assign adv       = !s8_valid_r || !out_full_i;
  assign mid_pop_o = adv && !mid_empty_i;
  assign wr_y      = mid_pop_o && (item.kind == chi_pkg::KIND_LOAD_Y);
  assign wr_s      = mid_pop_o && (item.kind == chi_pkg::KIND_LOAD_S);
  assign is_calc   = (item.kind == chi_pkg::KIND_EVAL) || (item.kind == chi_pkg::KIND_ERR);
  assign addr_m1   = item.index - AW'(1);
  assign addr_p1   = item.index + AW'(1);
  assign addr_p2   = item.index + AW'(2);

  // Two sample copies give the four neighbors y[i-1..i+2] together
  always_ff @(posedge clk) begin
    if (wr_y) begin
      ya_mem[item.index] <= item.value;
    end
    if (adv) begin
      ym1_r <= ya_mem[addr_m1];
      y0_r  <= ya_mem[item.index];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_y) begin
      yb_mem[item.index] <= item.value;
    end
    if (adv) begin
      y1_r <= yb_mem[addr_p1];
      y2_r <= yb_mem[addr_p2];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_s) begin
      sl_mem[item.index] <= item.value;
    end
    if (adv) begin
      sl0_r <= sl_mem[item.index];
      sl1_r <= sl_mem[addr_p1];
    end
  end

  // ---- stage 1 combinational: twice the scaled slopes
  logic signed [chi_pkg::DS_W-1:0] ym1_x, y0_x, y1_x, y2_x;
  logic signed [chi_pkg::DS_W-1:0] fd_first, fd_last, fd_mid0, fd_mid1, d0, d1;

  assign ym1_x    = chi_pkg::DS_W'(ym1_r);
  assign y0_x     = chi_pkg::DS_W'(y0_r);
  assign y1_x     = chi_pkg::DS_W'(y1_r);
  assign y2_x     = chi_pkg::DS_W'(y2_r);
  assign fd_first = (y1_x <<< 2) - (y0_x <<< 1) - y0_x - y2_x;
  assign fd_last  = (y1_x <<< 1) + y1_x - (y0_x <<< 2) + ym1_x;
  assign fd_mid0  = y1_x - ym1_x;
  assign fd_mid1  = y2_x - y0_x;

  always_comb begin
    if (cfg_i.slope_source) begin
      d0 = chi_pkg::DS_W'(sl0_r) <<< 1;
      d1 = chi_pkg::DS_W'(sl1_r) <<< 1;
    end else begin
      d0 = s1_first_r ? fd_first : fd_mid0;
      d1 = s1_last_r  ? fd_last  : fd_mid1;
    end
  end

  // ---- stage 2 combinational: cubic and quadratic coefficients
  logic signed [chi_pkg::DD_W-1:0] dd_diff, dd;
  logic signed [chi_pkg::C_W-1:0]  c_diff, cc;

  assign dd_diff = chi_pkg::DD_W'(s2_y0_r) - chi_pkg::DD_W'(s2_y1_r);
  assign dd      = (dd_diff <<< 2) + chi_pkg::DD_W'(s2_d0_r) + chi_pkg::DD_W'(s2_d1_r);
  assign c_diff  = chi_pkg::C_W'(s2_y1_r) - chi_pkg::C_W'(s2_y0_r);
  assign cc      = (c_diff <<< 2) + (c_diff <<< 1) - (chi_pkg::C_W'(s2_d0_r) <<< 1)
                   - chi_pkg::C_W'(s2_d1_r);

  // ---- stage 3..8 combinational: Horner steps in t
  logic signed [FW:0]                f3_s, f5_s, f7_s;
  logic signed [chi_pkg::X1_W-1:0]   m1, x1;
  logic signed [chi_pkg::X1_HI_W-1:0] x1_hi;
  logic [chi_pkg::X1_LO_W-1:0]       x1_lo;
  logic signed [chi_pkg::P1H_W-1:0]  ph1;
  logic [chi_pkg::P1L_W-1:0]         pl1;
  logic signed [chi_pkg::X2_W-1:0]   x2;
  logic signed [chi_pkg::X2_HI_W-1:0] x2_hi;
  logic [chi_pkg::X2_LO_W-1:0]       x2_lo;
  logic signed [chi_pkg::P2H_W-1:0]  ph2;
  logic [chi_pkg::P2L_W-1:0]         pl2;
  logic signed [chi_pkg::X3_W-1:0]   x3;

  assign f3_s  = $signed({1'b0, s3_frac_r});
  assign f5_s  = $signed({1'b0, s5_frac_r});
  assign f7_s  = $signed({1'b0, s7_frac_r});

  assign m1    = chi_pkg::X1_W'(s3_dd_r) * chi_pkg::X1_W'(f3_s);
  assign x1    = s4_m1_r + (chi_pkg::X1_W'(s4_c_r) <<< chi_pkg::FRAC_BITS);

  assign x1_hi = s5_x1_r[chi_pkg::X1_W-1:chi_pkg::X1_LO_W];
  assign x1_lo = s5_x1_r[chi_pkg::X1_LO_W-1:0];
  assign ph1   = chi_pkg::P1H_W'(x1_hi) * chi_pkg::P1H_W'(f5_s);
  assign pl1   = chi_pkg::P1L_W'(x1_lo) * chi_pkg::P1L_W'(s5_frac_r);

  assign x2    = (chi_pkg::X2_W'(s6_ph_r) <<< chi_pkg::X1_LO_W)
                 + $signed(chi_pkg::X2_W'(s6_pl_r))
                 + (chi_pkg::X2_W'(s6_d0_r) <<< (2 * chi_pkg::FRAC_BITS));

  assign x2_hi = s7_x2_r[chi_pkg::X2_W-1:chi_pkg::X2_LO_W];
  assign x2_lo = s7_x2_r[chi_pkg::X2_LO_W-1:0];
  assign ph2   = chi_pkg::P2H_W'(x2_hi) * chi_pkg::P2H_W'(f7_s);
  assign pl2   = chi_pkg::P2L_W'(x2_lo) * chi_pkg::P2L_W'(s7_frac_r);

  // final sum carries the rounding half; only the top RES_BITS bits are kept as the result
  assign x3    = (chi_pkg::X3_W'(s8_ph_r) <<< chi_pkg::X2_LO_W)
                 + $signed(chi_pkg::X3_W'(s8_pl_r))
                 + (chi_pkg::X3_W'(s8_y0_r) <<< (3 * chi_pkg::FRAC_BITS + 1))
                 + (chi_pkg::X3_W'(1) <<< (3 * chi_pkg::FRAC_BITS));

  assign out_push_o        = s8_valid_r && !out_full_i;
  assign out_data_o.status = s8_err_r;
  assign out_data_o.result = s8_err_r ? '0 : x3[chi_pkg::X3_W-1 -: chi_pkg::RES_BITS];

  // ---- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= mid_pop_o && is_calc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
      s8_valid_r <= s7_valid_r;
    end
  end

  // ---- payload chain, held while the output side stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err_r   <= (item.kind == chi_pkg::KIND_ERR);
      s1_first_r <= item.first;
      s1_last_r  <= item.last;
      s1_frac_r  <= item.frac;

      s2_err_r   <= s1_err_r;
      s2_frac_r  <= s1_frac_r;
      s2_y0_r    <= y0_r;
      s2_y1_r    <= y1_r;
      s2_d0_r    <= d0;
      s2_d1_r    <= d1;

      s3_err_r   <= s2_err_r;
      s3_frac_r  <= s2_frac_r;
      s3_y0_r    <= s2_y0_r;
      s3_d0_r    <= s2_d0_r;
      s3_dd_r    <= dd;
      s3_c_r     <= cc;

      s4_err_r   <= s3_err_r;
      s4_frac_r  <= s3_frac_r;
      s4_y0_r    <= s3_y0_r;
      s4_d0_r    <= s3_d0_r;
      s4_c_r     <= s3_c_r;
      s4_m1_r    <= m1;

      s5_err_r   <= s4_err_r;
      s5_frac_r  <= s4_frac_r;
      s5_y0_r    <= s4_y0_r;
      s5_d0_r    <= s4_d0_r;
      s5_x1_r    <= x1;

      s6_err_r   <= s5_err_r;
      s6_frac_r  <= s5_frac_r;
      s6_y0_r    <= s5_y0_r;
      s6_d0_r    <= s5_d0_r;
      s6_ph_r    <= ph1;
      s6_pl_r    <= pl1;

      s7_err_r   <= s6_err_r;
      s7_frac_r  <= s6_frac_r;
      s7_y0_r    <= s6_y0_r;
      s7_x2_r    <= x2;

      s8_err_r   <= s7_err_r;
      s8_y0_r    <= s7_y0_r;
      s8_ph_r    <= ph2;
      s8_pl_r    <= pl2;
    end
  end

`ifndef SYNTHESIS
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop_o && (item.kind == chi_pkg::KIND_LOAD_Y || item.kind == chi_pkg::KIND_LOAD_S))
      |=> !s1_valid_r)
    else $error("load request entered the arithmetic pipeline");

  a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop_o && (item.kind == chi_pkg::KIND_EVAL || item.kind == chi_pkg::KIND_ERR))
      |=> s1_valid_r)
    else $error("evaluate request lost at pipeline entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s8_valid_r && out_full_i)
      |=> (s8_valid_r && $stable(s8_ph_r) && $stable(s8_pl_r) && $stable(s8_err_r)))
    else $error("last stage changed while output was full");
`endif

endmodule

@@ design/cubic_hermite_interpolator_top.sv @@
`timescale 1ns / 1ps
// Cubic Hermite interpolator, one request per cycle sustained while the output queue has room.
// Path: a request's table read is registered as it leaves the input queue, it passes
// seven arithmetic stages, and its result is written into the output queue.
// Throughput: one request per cycle while output has room; loads take one queue slot, unused operations none.
// Reset: rst_n synchronous, active low; clears queues, pipeline valids and config
// (point_count 3, slope_source 0). Sample and slope tables are not cleared.

module cubic_hermite_interpolator_top #(
  parameter int QUEUE_DEPTH = chi_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = chi_pkg::OUT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  chi_pkg::in_item_t            in_data,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output chi_pkg::out_item_t           out_data,
  input  logic                         valid,
  output logic                         ready,
  input  logic                         cfg_index,
  input  logic [chi_pkg::CNT_BITS-1:0] cfg_data
);

  localparam int MID_W = $bits(chi_pkg::mid_item_t);
  localparam int OUT_W = $bits(chi_pkg::out_item_t);

  chi_pkg::cfg_t      cfg;
  chi_pkg::mid_item_t mid_in, mid_out;
  logic [MID_W-1:0]   mid_out_bits;
  logic               mid_push, mid_full, mid_pop, mid_empty;
  chi_pkg::out_item_t res_in;
  logic [OUT_W-1:0]   res_out_bits;
  logic               res_push, res_full;

  chi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push_i   (push),
    .in_data_i   (in_data),
    .in_full_o   (full),
    .cfg_valid_i (valid),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cfg_ready_o (ready),
    .cfg_o       (cfg),
    .mid_push_o  (mid_push),
    .mid_data_o  (mid_in),
    .mid_full_i  (mid_full)
  );

  chi_queue #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out_bits),
    .empty_o (mid_empty)
  );

  assign mid_out = chi_pkg::mid_item_t'(mid_out_bits);

  chi_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .mid_data_i  (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (res_push),
    .out_data_o  (res_in),
    .out_full_i  (res_full)
  );

  chi_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty)
  );

  assign out_data = chi_pkg::out_item_t'(res_out_bits);

endmodule
